// ===== sv/hlc_pkg.sv =====
`timescale 1ns / 1ps
// Hangul/Latin composer package: code point type, Jamo and syllable constants,
// Latin diacritic table, controller state and command/status types. No dependencies.
package hlc_pkg;

  localparam int CpWidth = 21;
  typedef logic [CpWidth-1:0] cp_t;

  localparam cp_t SYL_BASE   = 21'h00AC00;
  localparam cp_t LEAD_BASE  = 21'h001100;
  localparam cp_t VOWEL_BASE = 21'h001161;
  localparam cp_t TAIL_BASE  = 21'h0011A7;
  localparam int  LeadNum    = 19;
  localparam int  VowelNum   = 21;
  localparam int  TailNum    = 28;
  localparam int  SylNum     = LeadNum * VowelNum * TailNum;

  localparam int DiacEntries = 54;

  localparam logic [7:0] DIAC_LETTER [DiacEntries] = '{
    8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61,
    8'h65, 8'h65, 8'h65, 8'h65,
    8'h69, 8'h69, 8'h69, 8'h69,
    8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F,
    8'h75, 8'h75, 8'h75, 8'h75,
    8'h6E, 8'h63,
    8'h79, 8'h79,
    8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41,
    8'h45, 8'h45, 8'h45, 8'h45,
    8'h49, 8'h49, 8'h49, 8'h49,
    8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F,
    8'h55, 8'h55, 8'h55, 8'h55,
    8'h4E, 8'h43,
    8'h59, 8'h59
  };

  localparam logic [15:0] DIAC_MARK [DiacEntries] = '{
    16'h0300, 16'h0301, 16'h0302, 16'h0303, 16'h0308, 16'h030A,
    16'h0300, 16'h0301, 16'h0302, 16'h0308,
    16'h0300, 16'h0301, 16'h0302, 16'h0308,
    16'h0300, 16'h0301, 16'h0302, 16'h0303, 16'h0308,
    16'h0300, 16'h0301, 16'h0302, 16'h0308,
    16'h0303, 16'h0327,
    16'h0301, 16'h0308,
    16'h0300, 16'h0301, 16'h0302, 16'h0303, 16'h0308, 16'h030A,
    16'h0300, 16'h0301, 16'h0302, 16'h0308,
    16'h0300, 16'h0301, 16'h0302, 16'h0308,
    16'h0300, 16'h0301, 16'h0302, 16'h0303, 16'h0308,
    16'h0300, 16'h0301, 16'h0302, 16'h0308,
    16'h0303, 16'h0327,
    16'h0301, 16'h0308
  };

  localparam logic [8:0] DIAC_RESULT [DiacEntries] = '{
    9'h0E0, 9'h0E1, 9'h0E2, 9'h0E3, 9'h0E4, 9'h0E5,
    9'h0E8, 9'h0E9, 9'h0EA, 9'h0EB,
    9'h0EC, 9'h0ED, 9'h0EE, 9'h0EF,
    9'h0F2, 9'h0F3, 9'h0F4, 9'h0F5, 9'h0F6,
    9'h0F9, 9'h0FA, 9'h0FB, 9'h0FC,
    9'h0F1, 9'h0E7,
    9'h0FD, 9'h0FF,
    9'h0C0, 9'h0C1, 9'h0C2, 9'h0C3, 9'h0C4, 9'h0C5,
    9'h0C8, 9'h0C9, 9'h0CA, 9'h0CB,
    9'h0CC, 9'h0CD, 9'h0CE, 9'h0CF,
    9'h0D2, 9'h0D3, 9'h0D4, 9'h0D5, 9'h0D6,
    9'h0D9, 9'h0DA, 9'h0DB, 9'h0DC,
    9'h0D1, 9'h0C7,
    9'h0DD, 9'h178
  };

  typedef enum logic [1:0] {
    S_TAKE   = 2'b01,
    S_SECOND = 2'b10
  } hlc_state_t;

  typedef struct packed {
    logic take_item;
    logic load_first;
    logic load_second;
  } hlc_cmd_t;

  typedef struct packed {
    logic [1:0] results;
  } hlc_status_t;

  function automatic logic is_lead(cp_t c);
    return (c >= LEAD_BASE) && (c < LEAD_BASE + CpWidth'(LeadNum));
  endfunction

  function automatic logic is_vowel(cp_t c);
    return (c >= VOWEL_BASE) && (c < VOWEL_BASE + CpWidth'(VowelNum));
  endfunction

  function automatic logic is_tail(cp_t c);
    return (c > TAIL_BASE) && (c < TAIL_BASE + CpWidth'(TailNum));
  endfunction

  // Syllable with no trailing consonant: offset divisible by 4 and by 7.
  // Mod 7 by folding octal digits (8 = 1 mod 7).
  function automatic logic is_open_syllable(cp_t c);
    cp_t        off;
    logic [11:0] q;
    logic [4:0]  s1;
    logic [3:0]  s2;
    logic        in_range;
    off      = c - SYL_BASE;
    in_range = (c >= SYL_BASE) && (c < SYL_BASE + CpWidth'(SylNum));
    q        = off[13:2];
    s1       = 5'(q[2:0]) + 5'(q[5:3]) + 5'(q[8:6]) + 5'(q[11:9]);
    s2       = 4'(s1[2:0]) + 4'(s1[4:3]);
    return in_range && (off[1:0] == 2'b00) && ((s2 == 4'd0) || (s2 == 4'd7));
  endfunction

  function automatic logic is_letter_base(cp_t c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < DiacEntries; i++) begin
      if (c == CpWidth'(DIAC_LETTER[i])) hit = 1'b1;
    end
    return hit;
  endfunction

  // {hit, precomposed value}
  function automatic logic [9:0] precompose(cp_t letter, cp_t mark);
    logic [9:0] r;
    r = '0;
    for (int i = 0; i < DiacEntries; i++) begin
      if ((letter == CpWidth'(DIAC_LETTER[i])) && (mark == CpWidth'(DIAC_MARK[i])))
        r = {1'b1, DIAC_RESULT[i]};
    end
    return r;
  endfunction

  // SYL_BASE + (l * 21 + v) * 28, with the constant products as shift-adds
  function automatic cp_t syllable(cp_t lead, cp_t vowel);
    logic [4:0]  l;
    logic [4:0]  v;
    logic [8:0]  idx;
    logic [13:0] s;
    l   = 5'(lead - LEAD_BASE);
    v   = 5'(vowel - VOWEL_BASE);
    idx = 9'({l, 4'b0}) + 9'({l, 2'b0}) + 9'(l) + 9'(v);
    s   = 14'({idx, 5'b0}) - 14'({idx, 2'b0});
    return SYL_BASE + CpWidth'(s);
  endfunction

  function automatic logic [4:0] tail_offset(cp_t c);
    return 5'(c - TAIL_BASE);
  endfunction

  function automatic logic may_compose(cp_t c);
    return is_lead(c) || is_open_syllable(c) || is_letter_base(c);
  endfunction

endpackage

// ===== sv/hlc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the composer: valid/ready plus one code point word.
// Depends on hlc_pkg.
interface hlc_in_if import hlc_pkg::*;;
  logic valid;
  logic ready;
  cp_t  code_point;
  logic end_of_string;

  modport source(output valid, output code_point, output end_of_string, input ready);
  modport sink(input valid, input code_point, input end_of_string, output ready);
endinterface

// ===== sv/hlc_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the composer: valid/ready plus one composed code point word.
// Depends on hlc_pkg.
interface hlc_out_if import hlc_pkg::*;;
  logic valid;
  logic ready;
  cp_t  composed_point;
  logic last_point;

  modport source(output valid, output composed_point, output last_point, input ready);
  modport sink(input valid, input composed_point, input last_point, output ready);
endinterface

// ===== sv/hangul_latin_composer.sv =====
`timescale 1ns / 1ps
// Top level of the Hangul/Latin composer: controller plus datapath on two
// valid/ready channels. Depends on hlc_pkg, hlc_in_if, hlc_out_if.
//
// Usage:
//   code_stream carries one decoded code point word per handshake with an
//   end_of_string flag on the final word of a string. composed_stream returns
//   composed or passed-through code points; last_point marks the final word of
//   the string. Lead+vowel(+trailing) Jamo become syllables, an open syllable
//   absorbs a trailing Jamo, and a Latin letter followed by a listed combining
//   mark becomes its precomposed letter; anything else passes through.
//   Up to two points are held back waiting for a continuation, so a word may
//   release zero, one or two result words; end_of_string flushes them all.
//
// Output timing and flow:
//   A result appears on composed_stream the cycle after the word that releases
//   it is accepted. A word that releases two results holds off the next word,
//   since both leave through the single output register, one per cycle when
//   the receiver is ready; any other word leaves the input free for the next.
//
// Reset (rst, synchronous) empties the pending points and the output register.
// When the receiver stalls, the output word holds and code_stream.ready drops
// until the output register can be reloaded; nothing is lost or dropped.
module hangul_latin_composer import hlc_pkg::*; (
  input logic      clk,
  input logic      rst,
  hlc_in_if.sink   code_stream,
  hlc_out_if.source composed_stream
);

  hlc_cmd_t    cmd;
  hlc_status_t status;

  // Sequencing and handshakes
  hlc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (code_stream.valid),
    .out_ready (composed_stream.ready),
    .status    (status),
    .in_ready  (code_stream.ready),
    .out_valid (composed_stream.valid),
    .cmd       (cmd)
  );

  // Composition logic, pending points and output word
  hlc_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .code_point     (code_stream.code_point),
    .end_of_string  (code_stream.end_of_string),
    .cmd            (cmd),
    .status         (status),
    .composed_point (composed_stream.composed_point),
    .last_point     (composed_stream.last_point)
  );

endmodule

// ===== sv/hlc_datapath.sv =====
`timescale 1ns / 1ps
// Composer datapath: pending code points, composition decision, output and
// second-result registers. Depends on hlc_pkg.
module hlc_datapath import hlc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cp_t         code_point,
  input  logic        end_of_string,
  input  hlc_cmd_t    cmd,
  output hlc_status_t status,
  output cp_t         composed_point,
  output logic        last_point
);

  cp_t        p0;
  cp_t        p1;
  logic [1:0] count;
  cp_t        hold;
  logic       hold_last;

  cp_t        p0_next;
  cp_t        p1_next;
  logic [1:0] count_next;
  cp_t        r0;
  cp_t        r1;
  logic [1:0] k;
  logic       x_waits;
  logic       then_x;
  cp_t        syl;
  logic [9:0] pc;

  always_comb begin
    x_waits    = may_compose(code_point) && !end_of_string;
    syl        = syllable(p0, (count == 2'd2) ? p1 : code_point);
    pc         = precompose(p0, code_point);
    k          = 2'd0;
    r0         = code_point;
    r1         = code_point;
    p0_next    = p0;
    p1_next    = p1;
    count_next = 2'd0;
    then_x     = 1'b0;
    case (count)
      2'd0: begin
        if (x_waits) begin
          count_next = 2'd1;
          p0_next    = code_point;
        end else begin
          k = 2'd1;
        end
      end
      2'd1: begin
        if (is_lead(p0)) begin
          if (is_vowel(code_point)) begin
            if (end_of_string) begin
              k  = 2'd1;
              r0 = syl;
            end else begin
              count_next = 2'd2;
              p1_next    = code_point;
            end
          end else begin
            r0     = p0;
            then_x = 1'b1;
          end
        end else if (is_open_syllable(p0)) begin
          if (is_tail(code_point)) begin
            k  = 2'd1;
            r0 = p0 + CpWidth'(tail_offset(code_point));
          end else begin
            r0     = p0;
            then_x = 1'b1;
          end
        end else begin
          if (pc[9]) begin
            k  = 2'd1;
            r0 = CpWidth'(pc[8:0]);
          end else begin
            r0     = p0;
            then_x = 1'b1;
          end
        end
      end
      2'd2: begin
        if (is_tail(code_point)) begin
          k  = 2'd1;
          r0 = syl + CpWidth'(tail_offset(code_point));
        end else begin
          r0     = syl;
          then_x = 1'b1;
        end
      end
      default: begin
        k = 2'd1;
      end
    endcase
    // pending fully released by the first word; the new point follows
    if (then_x) begin
      if (x_waits) begin
        k          = 2'd1;
        count_next = 2'd1;
        p0_next    = code_point;
      end else begin
        k = 2'd2;
      end
    end
  end

  assign status.results = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (cmd.take_item) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      p0        <= p0_next;
      p1        <= p1_next;
      hold      <= r1;
      hold_last <= end_of_string;
    end
    if (cmd.load_first) begin
      composed_point <= r0;
      last_point     <= end_of_string && (k == 2'd1);
    end else if (cmd.load_second) begin
      composed_point <= hold;
      last_point     <= hold_last;
    end
  end

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item && end_of_string |=> count == 2'd0)
    else $error("end of string left points pending");

  a_pair_is_lead_vowel: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> is_lead(p0) && is_vowel(p1))
    else $error("two pending points are not a lead/vowel pair");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("pending count out of range");

endmodule

// ===== sv/hlc_controller.sv =====
`timescale 1ns / 1ps
// Composer controller: input/output handshake and sequencing of the second
// result word. Depends on hlc_pkg.
module hlc_controller import hlc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        out_ready,
  input  hlc_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output hlc_cmd_t    cmd
);

  hlc_state_t state;
  hlc_state_t state_next;
  logic       out_valid_next;
  logic       out_free;

  always_comb begin
    out_free       = !out_valid || out_ready;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      S_TAKE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.take_item = 1'b1;
          if (status.results != 2'd0) begin
            cmd.load_first = 1'b1;
            out_valid_next = 1'b1;
          end
          if (status.results == 2'd2) state_next = S_SECOND;
        end
      end
      S_SECOND: begin
        if (out_free) begin
          cmd.load_second = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_TAKE;
        end
      end
      default: begin
        state_next = S_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_TAKE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_take_in_second: assert property (@(posedge clk) disable iff (rst)
    state == S_SECOND |-> !cmd.take_item && !in_ready)
    else $error("word taken while second result pending");

  a_two_results_sequence: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item && status.results == 2'd2 |=> state == S_SECOND && out_valid)
    else $error("second result not scheduled");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

endmodule

// ===== verif/hangul_latin_composer_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hangul_latin_composer: directed probe rows, then random strings
// under four idle profiles. Depends on hlc_pkg, hlc_in_if, hlc_out_if and the composer RTL.
module hangul_latin_composer_test import hlc_pkg::*;;

  // Hangul arithmetic for the predictor
  localparam cp_t HangulBase  = 21'h00AC00;
  localparam cp_t LeadFirst   = 21'h001100;
  localparam cp_t VowelFirst  = 21'h001161;
  localparam cp_t TailOrigin  = 21'h0011A7;
  localparam int  LeadCount   = 19;
  localparam int  VowelCount  = 21;
  localparam int  TailCount   = 28;
  localparam int  SyllableCount = LeadCount * VowelCount * TailCount;

  // Latin compositions: {letter[27:20], mark low byte[19:12], precomposed[11:0]};
  // every mark sits in the U+03xx block.
  localparam int LatinPairs = 54;
  localparam logic [27:0] LATIN_COMPOSITIONS [LatinPairs] = '{
    28'h61_00_0E0, 28'h61_01_0E1, 28'h61_02_0E2, 28'h61_03_0E3, 28'h61_08_0E4, 28'h61_0A_0E5,
    28'h65_00_0E8, 28'h65_01_0E9, 28'h65_02_0EA, 28'h65_08_0EB,
    28'h69_00_0EC, 28'h69_01_0ED, 28'h69_02_0EE, 28'h69_08_0EF,
    28'h6F_00_0F2, 28'h6F_01_0F3, 28'h6F_02_0F4, 28'h6F_03_0F5, 28'h6F_08_0F6,
    28'h75_00_0F9, 28'h75_01_0FA, 28'h75_02_0FB, 28'h75_08_0FC,
    28'h6E_03_0F1, 28'h63_27_0E7,
    28'h79_01_0FD, 28'h79_08_0FF,
    28'h41_00_0C0, 28'h41_01_0C1, 28'h41_02_0C2, 28'h41_03_0C3, 28'h41_08_0C4, 28'h41_0A_0C5,
    28'h45_00_0C8, 28'h45_01_0C9, 28'h45_02_0CA, 28'h45_08_0CB,
    28'h49_00_0CC, 28'h49_01_0CD, 28'h49_02_0CE, 28'h49_08_0CF,
    28'h4F_00_0D2, 28'h4F_01_0D3, 28'h4F_02_0D4, 28'h4F_03_0D5, 28'h4F_08_0D6,
    28'h55_00_0D9, 28'h55_01_0DA, 28'h55_02_0DB, 28'h55_08_0DC,
    28'h4E_03_0D1, 28'h43_27_0C7,
    28'h59_01_0DD, 28'h59_08_178
  };

  // Values just outside the Jamo and syllable ranges, and the top of the code space
  localparam int EdgeCount = 10;
  localparam cp_t EDGE_POINTS [EdgeCount] = '{
    21'h0010FF, 21'h001113, 21'h001160, 21'h001176, 21'h0011A7,
    21'h0011C3, 21'h00ABFF, 21'h00D7A4, 21'h10FFFF, 21'h110000
  };

  localparam int ResetCycles   = 9;
  localparam int HoldOffCycles = 400;
  localparam int QuietLimit    = 3000;
  localparam int TailCycles    = 8;
  localparam int PhaseWords    = 425;
  localparam int PhaseCount    = 4;
  localparam int PrintLimit    = 200;

  // Idle profiles per random phase: none, sender, receiver, both lightly
  localparam int SEND_IDLE_PCT [PhaseCount] = '{0, 82, 0, 6};
  localparam int RECV_STALL_PCT [PhaseCount] = '{0, 0, 82, 6};

  // One directed row; count/first/second are used only when typed is set
  typedef struct packed {
    cp_t        point;
    logic       fin;
    logic       typed;
    logic [1:0] count;
    cp_t        first;
    cp_t        second;
  } probe_row_t;

  localparam int ProbeRows = 26;
  localparam probe_row_t PROBES [ProbeRows] = '{
    // Latin letter waits, the mark composes and the end mark flushes
    '{21'h000061, 1'b0, 1'b1, 2'd0, 21'h0, 21'h0},
    '{21'h000301, 1'b1, 1'b1, 2'd1, 21'h0000E1, 21'h0},
    // the one result above U+FF
    '{21'h000059, 1'b0, 1'b1, 2'd0, 21'h0, 21'h0},
    '{21'h000308, 1'b1, 1'b1, 2'd1, 21'h000178, 21'h0},
    // first lead, first vowel, first tail
    '{21'h001100, 1'b0, 1'b1, 2'd0, 21'h0, 21'h0},
    '{21'h001161, 1'b0, 1'b1, 2'd0, 21'h0, 21'h0},
    '{21'h0011A8, 1'b1, 1'b1, 2'd1, 21'h00AC01, 21'h0},
    // last lead, last vowel, last tail: the top syllable
    '{21'h001112, 1'b0, 1'b1, 2'd0, 21'h0, 21'h0},
    '{21'h001175, 1'b0, 1'b1, 2'd0, 21'h0, 21'h0},
    '{21'h0011C2, 1'b1, 1'b1, 2'd1, 21'h00D7A3, 21'h0},
    // end mark on the vowel: open syllable
    '{21'h001100, 1'b0, 1'b1, 2'd0, 21'h0, 21'h0},
    '{21'h001161, 1'b1, 1'b1, 2'd1, 21'h00AC00, 21'h0},
    // open syllable followed by the value just below the tails
    '{21'h00AC00, 1'b0, 1'b1, 2'd0, 21'h0, 21'h0},
    '{21'h0011A7, 1'b0, 1'b1, 2'd2, 21'h00AC00, 21'h0011A7},
    // tail with nothing before it
    '{21'h0011A8, 1'b1, 1'b1, 2'd1, 21'h0011A8, 21'h0},
    // field extremes, values beyond U+10FFFF and the value just past the syllables pass through
    '{21'h1FFFFF, 1'b1, 1'b1, 2'd1, 21'h1FFFFF, 21'h0},
    '{21'h000000, 1'b0, 1'b1, 2'd1, 21'h000000, 21'h0},
    '{21'h00D7A4, 1'b0, 1'b1, 2'd1, 21'h00D7A4, 21'h0},
    // the rest goes through the predictor
    '{21'h000063, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
    '{21'h000327, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
    '{21'h001100, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
    '{21'h001100, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
    '{21'h001161, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
    '{21'h001100, 1'b1, 1'b0, 2'd0, 21'h0, 21'h0},
    '{21'h00AC1C, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
    '{21'h0011A8, 1'b1, 1'b0, 2'd0, 21'h0, 21'h0}
  };

  typedef struct {
    cp_t  point;
    logic fin;
  } text_word_t;

  typedef struct {
    cp_t  point;
    logic last;
  } composed_word_t;

  logic clk = 1'b0;
  logic rst;

  hlc_in_if  code_stream();
  hlc_out_if composed_stream();

  hangul_latin_composer dut (
    .clk             (clk),
    .rst             (rst),
    .code_stream     (code_stream),
    .composed_stream (composed_stream)
  );

  // Composition state of the predictor
  cp_t         held_points [2];
  int unsigned held_count = 0;
  cp_t         window_pts [3];

  composed_word_t composed_due [$];
  text_word_t     text_plan [$];

  // Typed expectation of the word currently offered by the sender
  logic       probe_typed = 1'b0;
  logic [1:0] probe_count = '0;
  cp_t        probe_first = '0;
  cp_t        probe_second = '0;

  int mismatches    = 0;
  int quiet_cycles  = 0;
  int hold_requests = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit jamo_lead(cp_t c);
    return (c >= LeadFirst) && (c < LeadFirst + LeadCount);
  endfunction

  function automatic bit jamo_vowel(cp_t c);
    return (c >= VowelFirst) && (c < VowelFirst + VowelCount);
  endfunction

  // TailOrigin itself means "no tail" and is not a trailing Jamo
  function automatic bit jamo_tail(cp_t c);
    return (c > TailOrigin) && (c < TailOrigin + TailCount);
  endfunction

  function automatic bit open_syllable(cp_t c);
    return (c >= HangulBase) && (c < HangulBase + SyllableCount) &&
           (((c - HangulBase) % TailCount) == 0);
  endfunction

  function automatic bit latin_base(cp_t c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < LatinPairs; i++)
      if (c == cp_t'(LATIN_COMPOSITIONS[i][27:20])) hit = 1'b1;
    return hit;
  endfunction

  function automatic bit latin_precompose(cp_t letter, cp_t mark, output cp_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    for (int i = 0; i < LatinPairs; i++) begin
      if ((letter == cp_t'(LATIN_COMPOSITIONS[i][27:20])) &&
          (mark == (21'h000300 | cp_t'(LATIN_COMPOSITIONS[i][19:12])))) begin
        hit = 1'b1;
        res = cp_t'(LATIN_COMPOSITIONS[i][8:0]);
      end
    end
    return hit;
  endfunction

  // Decide the head of the window: number of points it consumes, 0 to wait.
  function automatic int unsigned head_length(int unsigned n, bit fin, output cp_t res);
    cp_t h;
    cp_t syl;
    cp_t latin;
    h = window_pts[0];
    res = h;
    if (jamo_lead(h)) begin
      if (n < 2 && !fin) return 0;
      if (n >= 2 && jamo_vowel(window_pts[1])) begin
        syl = cp_t'(HangulBase + ((h - LeadFirst) * VowelCount +
                                  (window_pts[1] - VowelFirst)) * TailCount);
        if (n < 3 && !fin) return 0;
        if (n >= 3 && jamo_tail(window_pts[2])) begin
          res = cp_t'(syl + (window_pts[2] - TailOrigin));
          return 3;
        end
        res = syl;
        return 2;
      end
      return 1;
    end
    if (open_syllable(h)) begin
      if (n < 2 && !fin) return 0;
      if (n >= 2 && jamo_tail(window_pts[1])) begin
        res = cp_t'(h + (window_pts[1] - TailOrigin));
        return 2;
      end
      return 1;
    end
    if (latin_base(h)) begin
      if (n < 2 && !fin) return 0;
      if (n >= 2 && latin_precompose(h, window_pts[1], latin)) begin
        res = latin;
        return 2;
      end
      return 1;
    end
    return 1;
  endfunction

  // Advance the composer state by one word; queue its results when record is set.
  function automatic void compose_word(cp_t point, logic fin, bit record);
    int unsigned n;
    int unsigned used;
    int unsigned k;
    int unsigned i;
    cp_t res;
    for (i = 0; i < held_count; i++) window_pts[i] = held_points[i];
    window_pts[held_count] = point;
    n = held_count + 1;
    k = 0;
    while (n > 0 && k < 2) begin
      used = head_length(n, fin, res);
      if (used == 0 || used > n) break;
      if (record) composed_due.push_back('{point: res, last: 1'b0});
      k++;
      for (i = used; i < n; i++) window_pts[i - used] = window_pts[i];
      n -= used;
    end
    if (record && fin && k > 0) composed_due[composed_due.size() - 1].last = 1'b1;
    if (n > 2) n = 2;
    for (i = 0; i < n; i++) held_points[i] = window_pts[i];
    held_count = n;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: compare outputs first, then predict the accepted input word, all
  // at the rising edge so that the order against the driver does not matter.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, cp_t expected, cp_t got);
    if (mismatches < PrintLimit)
      $display("MISMATCH %s: expected %06h, got %06h at %0t ns", what, expected, got, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    composed_word_t due;
    bit in_taken;
    bit out_taken;
    if (!rst) begin
      in_taken  = code_stream.valid && code_stream.ready;
      out_taken = composed_stream.valid && composed_stream.ready;
      if (out_taken) begin
        if (composed_due.size() == 0) begin
          report_mismatch("composed word with nothing expected", '0,
                          composed_stream.composed_point);
        end else begin
          due = composed_due.pop_front();
          if (composed_stream.composed_point !== due.point)
            report_mismatch("composed_point", due.point, composed_stream.composed_point);
          if (composed_stream.last_point !== due.last)
            report_mismatch("last_point", cp_t'(due.last), cp_t'(composed_stream.last_point));
        end
      end
      if (in_taken) begin
        // typed rows queue what the table says; the predictor still tracks the state
        if (probe_typed) begin
          for (int k = 0; k < int'(probe_count); k++)
            composed_due.push_back('{point: (k == 0) ? probe_first : probe_second,
                                     last: code_stream.end_of_string &&
                                           (k == int'(probe_count) - 1)});
        end
        compose_word(code_stream.code_point, code_stream.end_of_string, !probe_typed);
      end
      quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
    end
  end

  // Stop a hung run: too many cycles in a row with no word moving either way
  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall at random per the phase profile; on request hold off for a
  // long stretch so that the composer fills up and drops code_stream.ready.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    composed_stream.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        composed_stream.ready <= 1'b0;
      end else begin
        composed_stream.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one word; called at a falling edge, returns at the falling edge after
  // the word is taken. valid gets one assignment per edge.
  task automatic send_word(cp_t point, logic fin, logic typed, logic [1:0] count,
                           cp_t first, cp_t second);
    while ($urandom_range(99) < send_idle_pct) begin
      code_stream.valid <= 1'b0;
      @(negedge clk);
    end
    code_stream.valid         <= 1'b1;
    code_stream.code_point    <= point;
    code_stream.end_of_string <= fin;
    probe_typed  = typed;
    probe_count  = count;
    probe_first  = first;
    probe_second = second;
    do @(posedge clk); while (!code_stream.ready);
    @(negedge clk);
  endtask

  // Hold the sender until every queued result has come back
  task automatic drain_results();
    code_stream.valid <= 1'b0;
    while (composed_due.size() != 0) @(negedge clk);
  endtask

  function automatic cp_t pick_lead();
    return cp_t'(LeadFirst + $urandom_range(LeadCount - 1));
  endfunction

  function automatic cp_t pick_vowel();
    return cp_t'(VowelFirst + $urandom_range(VowelCount - 1));
  endfunction

  function automatic cp_t pick_tail();
    return cp_t'(TailOrigin + 1 + $urandom_range(TailCount - 2));
  endfunction

  function automatic cp_t pick_open_syllable();
    return cp_t'(HangulBase + TailCount * $urandom_range(LeadCount * VowelCount - 1));
  endfunction

  function automatic cp_t pick_noise();
    case ($urandom_range(5))
      0: return cp_t'($urandom);
      1: return cp_t'($urandom_range(126, 32));
      2: return EDGE_POINTS[$urandom_range(EdgeCount - 1)];
      3: return cp_t'(HangulBase + $urandom_range(SyllableCount - 1));
      4: return cp_t'(21'h1FFFFF - $urandom_range(3));
      default: return $urandom_range(1) ? pick_vowel() : pick_tail();
    endcase
  endfunction

  function automatic void add_word(cp_t point);
    text_plan.push_back('{point: point, fin: 1'b0});
  endfunction

  // Queue one string: mostly well-formed snippets with random content, some
  // broken sequences and noise; the end mark closes most strings.
  function automatic void build_string();
    int pick;
    int entry;
    repeat ($urandom_range(5, 1)) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        add_word(pick_lead());
        add_word(pick_vowel());
        if ($urandom_range(1)) add_word(pick_tail());
      end else if (pick < 45) begin
        add_word(pick_open_syllable());
        add_word(($urandom_range(9) < 7) ? pick_tail() : pick_noise());
      end else if (pick < 65) begin
        entry = $urandom_range(LatinPairs - 1);
        add_word(cp_t'(LATIN_COMPOSITIONS[entry][27:20]));
        if ($urandom_range(9) < 7)
          add_word(21'h000300 | cp_t'(LATIN_COMPOSITIONS[entry][19:12]));
        else
          add_word(cp_t'($urandom_range(21'h00036F, 21'h000300)));
      end else if (pick < 72) begin
        add_word(pick_lead());
        add_word(pick_noise());
      end else if (pick < 78) begin
        add_word(pick_lead());
        add_word(pick_vowel());
        add_word(pick_lead());
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0: add_word(pick_lead());
          1: add_word(pick_open_syllable());
          default: add_word(cp_t'(LATIN_COMPOSITIONS[$urandom_range(LatinPairs - 1)][27:20]));
        endcase
      end else begin
        add_word(pick_noise());
      end
    end
    text_plan[text_plan.size() - 1].fin = ($urandom_range(9) != 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    text_word_t word;
    int sent;
    code_stream.valid         = 1'b0;
    code_stream.code_point    = '0;
    code_stream.end_of_string = 1'b0;
    rst = 1'b1;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows with no idling on either side
    for (int r = 0; r < ProbeRows; r++)
      send_word(PROBES[r].point, PROBES[r].fin, PROBES[r].typed, PROBES[r].count,
                PROBES[r].first, PROBES[r].second);
    drain_results();

    // Random strings, one idle profile per phase, draining between phases
    for (int p = 0; p < PhaseCount; p++) begin
      send_idle_pct  = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      sent = 0;
      while (sent < PhaseWords) begin
        build_string();
        while (text_plan.size() != 0) begin
          word = text_plan.pop_front();
          send_word(word.point, word.fin, 1'b0, 2'd0, '0, '0);
          sent++;
          // back-pressure while the sender keeps offering
          if (p == 0 && sent == 150) hold_requests++;
        end
      end
      drain_results();
    end

    // let any stray result show up before the verdict
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
